FILE: rtl/tlpt_pkg.sv
// Package with types and constants for the two-level page table engine.
package tlpt_pkg;

  localparam int unsigned DirEntries   = 1024;
  localparam int unsigned TableEntries = 1024;
  localparam int unsigned TableSlots   = 64;

  localparam logic [31:0] FrameMask = 32'hFFFF_F000;

  typedef enum logic [1:0] {
    REQ_TRANSLATE = 2'd0,
    REQ_MAP       = 2'd1,
    REQ_UNMAP     = 2'd2,
    REQ_NONE      = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIR_ABS  = 2'd1,
    ST_PAGE_ABS = 2'd2,
    ST_NO_SLOT  = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] virt_addr;
    logic [31:0] phys_addr_in;
    logic [11:0] map_flags;
    logic [31:0] pt_base;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] phys_addr_out;
    logic [31:0] entry_value;
  } rsp_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_DIR_RD,
    S_DECIDE,
    S_CLEAR,
    S_ENT_RD,
    S_ENT_WR,
    S_RESP
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic init_step;
    logic load_req;
    logic dir_rd;
    logic dir_alloc;
    logic clr_start;
    logic clr_step;
    logic ent_rd;
    logic ent_wr;
    logic rsp_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] req_type;
    logic       dir_present;
    logic       slots_full;
    logic       clr_done;
    logic       init_done;
  } sts_t;

endpackage

FILE: rtl/tlpt_ctrl.sv
// Controller state machine for the two-level page table engine.
module tlpt_ctrl
  import tlpt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  logic out_valid_i,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // A request is fully done once its result reaches the output register.
  assign busy = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_INIT:   if (sts_i.init_done) state_d = S_IDLE;
      S_IDLE:   if (in_valid_i) state_d = S_DIR_RD;
      S_DIR_RD: state_d = S_DECIDE;
      S_DECIDE: begin
        case (sts_i.req_type)
          REQ_TRANSLATE, REQ_UNMAP:
            state_d = sts_i.dir_present ? S_ENT_RD : S_RESP;
          REQ_MAP: begin
            if (sts_i.dir_present) state_d = S_ENT_RD;
            else if (sts_i.slots_full) state_d = S_RESP;
            else state_d = S_CLEAR;
          end
          default: state_d = S_RESP;
        endcase
      end
      S_CLEAR:  if (sts_i.clr_done) state_d = S_ENT_RD;
      S_ENT_RD: state_d = S_ENT_WR;
      S_ENT_WR: state_d = S_RESP;
      S_RESP:   if (!out_valid_i || !out_stall_i) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = busy;
    case (state_q)
      S_INIT:   cmd_o.init_step = 1'b1;
      S_IDLE:   cmd_o.load_req = in_valid_i;
      S_DIR_RD: cmd_o.dir_rd = 1'b1;
      S_DECIDE: begin
        if (sts_i.req_type == REQ_MAP && !sts_i.dir_present && !sts_i.slots_full) begin
          cmd_o.dir_alloc = 1'b1;
          cmd_o.clr_start = 1'b1;
        end
      end
      S_CLEAR:  cmd_o.clr_step = 1'b1;
      S_ENT_RD: cmd_o.ent_rd = 1'b1;
      S_ENT_WR: cmd_o.ent_wr = 1'b1;
      S_RESP:   cmd_o.rsp_load = !out_valid_i || !out_stall_i;
      default:  cmd_o = '0;
    endcase
  end

endmodule

FILE: rtl/tlpt_dpath.sv
// Datapath of the two-level page table engine: directory, table memory, result register.
module tlpt_dpath
  import tlpt_pkg::*;
#(
  parameter int unsigned TABLE_SLOTS = TableSlots
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  req_t req_i,
  input  cmd_t cmd_i,
  output sts_t sts_o,
  input  logic out_stall_i,
  output logic out_valid_o,
  output rsp_t rsp_o
);

  localparam int unsigned SlotW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned CntW  = $clog2(TABLE_SLOTS + 1);
  localparam int unsigned DirW  = $clog2(DirEntries);
  localparam int unsigned TblW  = $clog2(TableEntries);
  localparam int unsigned MemW  = SlotW + TblW;

  req_t              req_q;
  logic [CntW-1:0]   next_slot_q;
  logic [DirW-1:0]   dir_valid_idx;
  logic [DirW:0]     init_cnt_q;

  // Directory: entry and slot share one memory word, zeroed by a sweep after reset.
  logic [32+SlotW-1:0] dir_mem [DirEntries];
  logic [32+SlotW-1:0] dir_rd_q;
  logic [31:0]         dir_ent;
  logic [SlotW-1:0]    dir_slot;
  logic [31:0]         dir_new;

  logic [31:0]         tbl_mem [TABLE_SLOTS*TableEntries];
  logic [31:0]         ent_q;
  logic [31:0]         ent_new;
  logic [MemW-1:0]     ent_addr;
  logic [TblW:0]       clr_cnt_q;
  logic [SlotW-1:0]    clr_slot_q;

  logic [1:0]          st_q;
  logic                out_valid_q;
  rsp_t                rsp_d, rsp_q;

  assign dir_valid_idx = req_q.virt_addr[31:32-DirW];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) req_q <= req_i;
  end

  // Directory clearing sweep, one entry per cycle after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_cnt_q <= '0;
    end else if (cmd_i.init_step && !init_cnt_q[DirW]) begin
      init_cnt_q <= init_cnt_q + (DirW+1)'(1);
    end
  end

  // A created entry also refreshes the read register, so the walk goes on with it.
  always_ff @(posedge clk_i) begin
    if (cmd_i.dir_rd) dir_rd_q <= dir_mem[dir_valid_idx];
    else if (cmd_i.dir_alloc) dir_rd_q <= {dir_new, next_slot_q[SlotW-1:0]};
    if (cmd_i.init_step && !init_cnt_q[DirW]) begin
      dir_mem[init_cnt_q[DirW-1:0]] <= '0;
    end else if (cmd_i.dir_alloc) begin
      dir_mem[dir_valid_idx] <= {dir_new, next_slot_q[SlotW-1:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_slot_q <= '0;
    end else if (cmd_i.dir_alloc) begin
      next_slot_q <= next_slot_q + CntW'(1);
    end
  end

  assign dir_ent  = dir_rd_q[32+SlotW-1:SlotW];
  assign dir_slot = dir_rd_q[SlotW-1:0];
  assign dir_new  = ((dir_ent | 32'd3) & ~FrameMask) | req_q.pt_base;

  // Clearing sweep over the newly taken table.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_start) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_step && !clr_cnt_q[TblW]) begin
      clr_cnt_q <= clr_cnt_q + (TblW+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_start) clr_slot_q <= next_slot_q[SlotW-1:0];
  end

  always_comb begin
    if (cmd_i.clr_step) ent_addr = {clr_slot_q, clr_cnt_q[TblW-1:0]};
    else ent_addr = {dir_slot, req_q.virt_addr[12+TblW-1:12]};
  end

  always_comb begin
    case (req_q.req_type)
      REQ_MAP: ent_new = ((ent_q | {20'd0, req_q.map_flags}) & ~FrameMask) | req_q.phys_addr_in;
      default: ent_new = ent_q & ~FrameMask & ~32'd1;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ent_rd) ent_q <= tbl_mem[ent_addr];
    if (cmd_i.clr_step && !clr_cnt_q[TblW]) begin
      tbl_mem[ent_addr] <= 32'd0;
    end else if (cmd_i.ent_wr && (req_q.req_type == REQ_MAP ||
        (req_q.req_type == REQ_UNMAP && ent_q[0]))) begin
      tbl_mem[ent_addr] <= ent_new;
    end
  end

  // Track the outcome of the walk for the result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_OK;
    end else if (cmd_i.load_req) begin
      st_q <= ST_OK;
    end else if (cmd_i.dir_rd) begin
      st_q <= ST_OK;
    end else if (cmd_i.ent_wr) begin
      if (req_q.req_type != REQ_MAP && !ent_q[0]) st_q <= ST_PAGE_ABS;
    end
  end

  assign sts_o.req_type    = req_q.req_type;
  assign sts_o.dir_present = dir_ent[0];
  assign sts_o.slots_full  = (next_slot_q >= CntW'(TABLE_SLOTS));
  assign sts_o.clr_done    = clr_cnt_q[TblW];
  assign sts_o.init_done   = init_cnt_q[DirW];

  // Result register; it is loaded in the response state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.rsp_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_comb begin
    rsp_d = '0;
    case (req_q.req_type)
      REQ_TRANSLATE, REQ_UNMAP: begin
        if (!dir_ent[0]) begin
          rsp_d.status = ST_DIR_ABS;
        end else if (st_q == ST_PAGE_ABS) begin
          rsp_d.status      = ST_PAGE_ABS;
          rsp_d.entry_value = ent_q;
        end else if (req_q.req_type == REQ_TRANSLATE) begin
          rsp_d.phys_addr_out = (ent_q & FrameMask) + {20'd0, req_q.virt_addr[11:0]};
          rsp_d.entry_value   = ent_q;
        end else begin
          rsp_d.entry_value = ent_new;
        end
      end
      REQ_MAP: begin
        if (!dir_ent[0]) rsp_d.status = ST_NO_SLOT;
        else rsp_d.entry_value = ent_new;
      end
      default: rsp_d.status = ST_OK;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rsp_load) rsp_q <= rsp_d;
  end

  assign rsp_o       = rsp_q;
  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/two_level_page_table_engine_unit.sv
// A full walk goes through the directory read, decide, entry read, entry write and response states;
// a walk that stops at the directory, a map with no free slot or a no-op skips the entry states.
// Creating a table adds the clear state, which sweeps the new table. Items are taken one at a time:
// the dependent directory read, then table read and write, on one port each, serialise the walk.
// Reset is asynchronous and active low; the slot counter clears at once and a sweep of all 1024
// entries zeroes the directory before the first item is taken. Tables are swept when they are taken.
// Top level of the two-level page table engine.
module two_level_page_table_engine_unit
  import tlpt_pkg::*;
#(
  parameter int unsigned TABLE_SLOTS = TableSlots
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_data_o
);

  cmd_t cmd;
  sts_t sts;

  // The controller sequences each item through directory read, optional table
  // creation, entry read and write where the walk gets that far, and the result register. A result that
  // waits in the output register holds the controller in the response state while the output stalls.
  tlpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_i(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath holds all storage and produces the result item.
  tlpt_dpath #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .rsp_o      (out_data_o)
  );

  // An entry read and a table clear step never happen in the same cycle.
  a_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.ent_rd && cmd.clr_step))
    else $error("entry read during clear");

  // A new item is only taken when nothing is in flight, and its directory read follows.
  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_req |=> cmd.dir_rd)
    else $error("load not followed by directory read");

  // A table is only created when a slot is free.
  a_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.dir_alloc |-> !sts.slots_full)
    else $error("allocation with no free slot");

endmodule
